@@ hw/rtl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

  localparam int ChW     = 8;
  localparam int HueW    = 9;
  localparam int SatW    = 14;
  localparam int PairW   = 10;
  localparam int HueQW   = 7;
  localparam int HueNumW = 15;
  localparam int SatNumW = 22;

  localparam logic [5:0]  HueScale  = 6'd60;
  localparam logic [13:0] SatScale  = 14'd10000;
  localparam logic [9:0]  HueFull   = 10'd360;
  localparam logic [9:0]  BaseRed   = 10'd300;
  localparam logic [9:0]  BaseGreen = 10'd60;
  localparam logic [9:0]  BaseBlue  = 10'd180;

  // Which channel holds the maximum; grey means all channels are equal.
  typedef enum logic [1:0] {
    SecGrey,
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  typedef struct packed {
    logic [ChW-1:0]     value;
    logic [ChW-1:0]     diff;
    logic [PairW-1:0]   pair;
    sector_e            sector;
  } prep_t;

  typedef struct packed {
    logic [ChW-1:0]     value;
    sector_e            sector;
    logic [ChW-1:0]     sdiv;
    logic [SatNumW-1:0] srem;
    logic [SatW-1:0]    squo;
    logic [ChW-1:0]     hdiv;
    logic [HueNumW-1:0] hrem;
    logic [HueQW-1:0]   hquo;
  } div_t;

endpackage

@@ hw/rtl/rgb_to_hsv_pixel_converter.sv @@
// Converts one 8-bit RGB pixel per request into hue (whole degrees, 0 for
// grey), saturation (hundredths of a percent) and value (largest channel).
// The pipeline takes a new pixel every clock while the output is not stalled,
// and each result passes through the channel compare and product registers,
// the bit-per-stage restoring dividers (one saturation quotient bit per stage,
// the hue divider sharing the last seven) and one output register. A stall on
// the output side holds the whole pipeline in place, so s_axis_tready follows
// m_axis_tready whenever the output register is full.
module rgb_to_hsv_pixel_converter import rgbhsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // hue [8:0], saturation [22:9], value [30:23]
);

  logic            en;
  logic            stage_valid [SatW+1];
  div_t            stage_data  [SatW+1];
  logic [HueW-1:0] hue;
  logic [SatW-1:0] saturation;
  logic [ChW-1:0]  value;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (stage_valid[0]),
    .data_o  (stage_data[0])
  );

  for (genvar j = 0; j < SatW; j++) begin : g_div
    rgbhsv_div_step #(
      .Bit (SatW - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stage_valid[j]),
      .data_i  (stage_data[j]),
      .valid_o (stage_valid[j+1]),
      .data_o  (stage_data[j+1])
    );
  end

  rgbhsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (stage_valid[SatW]),
    .data_i       (stage_data[SatW]),
    .valid_o      (m_axis_tvalid),
    .hue_o        (hue),
    .saturation_o (saturation),
    .value_o      (value)
  );

  assign m_axis_tdata = {1'b0, value, saturation, hue};

endmodule

@@ hw/rtl/rgbhsv_front.sv @@
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [ChW-1:0] red_i,
  input  logic [ChW-1:0] green_i,
  input  logic [ChW-1:0] blue_i,
  output logic           valid_o,
  output div_t           data_o
);

  prep_t              prep_d, prep_q;
  logic               prep_valid_q;
  logic [ChW-1:0]     cmin;
  logic [HueNumW-1:0] hprod;
  logic [SatNumW-1:0] sprod;
  div_t               div_d, div_q;
  logic               div_valid_q;

  // Stage one: maximum, minimum, sector and the channel difference shifted
  // by diff so that it is never negative.
  always_comb begin
    prep_d = '0;
    cmin = red_i;
    if (green_i < cmin) cmin = green_i;
    if (blue_i < cmin) cmin = blue_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      prep_d.value = red_i;
      prep_d.diff  = red_i - cmin;
      prep_d.pair  = PairW'(green_i) + PairW'(prep_d.diff) - PairW'(blue_i);
      prep_d.sector = SecRed;
    end else if (green_i >= blue_i) begin
      prep_d.value = green_i;
      prep_d.diff  = green_i - cmin;
      prep_d.pair  = PairW'(blue_i) + PairW'(prep_d.diff) - PairW'(red_i);
      prep_d.sector = SecGreen;
    end else begin
      prep_d.value = blue_i;
      prep_d.diff  = blue_i - cmin;
      prep_d.pair  = PairW'(red_i) + PairW'(prep_d.diff) - PairW'(green_i);
      prep_d.sector = SecBlue;
    end
    if (prep_d.diff == '0) prep_d.sector = SecGrey;
  end

  // Stage two: the dividends of both divisions.
  always_comb begin
    hprod = HueNumW'(prep_q.pair) * HueNumW'(HueScale);
    sprod = SatNumW'(prep_q.diff) * SatNumW'(SatScale);
    div_d = '0;
    div_d.value  = prep_q.value;
    div_d.sector = prep_q.sector;
    div_d.sdiv   = prep_q.value;
    div_d.srem   = sprod;
    div_d.hdiv   = prep_q.diff;
    div_d.hrem   = hprod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
      div_valid_q  <= 1'b0;
    end else if (en_i) begin
      prep_valid_q <= valid_i;
      div_valid_q  <= prep_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = div_valid_q;
  assign data_o  = div_q;

endmodule

@@ hw/rtl/rgbhsv_div_step.sv @@
module rgbhsv_div_step import rgbhsv_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  localparam int unsigned HBit = (Bit < HueQW) ? Bit : 0;

  logic [SatNumW-1:0] sden;
  logic [HueNumW-1:0] hden;
  div_t               data_d, data_q;
  logic               valid_q;

  // One restoring step per stage for saturation; hue joins in the stages
  // that hold its lower quotient bits.
  always_comb begin
    data_d = data_i;
    sden = SatNumW'(data_i.sdiv) << Bit;
    hden = HueNumW'(data_i.hdiv) << HBit;
    if (data_i.srem >= sden) begin
      data_d.srem      = data_i.srem - sden;
      data_d.squo[Bit] = 1'b1;
    end
    if (Bit < HueQW && data_i.hrem >= hden) begin
      data_d.hrem       = data_i.hrem - hden;
      data_d.hquo[HBit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/rgbhsv_back.sv @@
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  div_t            data_i,
  output logic            valid_o,
  output logic [HueW-1:0] hue_o,
  output logic [SatW-1:0] saturation_o,
  output logic [ChW-1:0]  value_o
);

  logic [9:0]      base;
  logic [9:0]      sum;
  logic [HueW-1:0] hue_d, hue_q;
  logic [SatW-1:0] sat_d, sat_q;
  logic [ChW-1:0]  value_q;
  logic            valid_q;

  // The quotient covers 60*(pair+diff)/diff, so the sector base is the
  // nominal offset less 60.
  always_comb begin
    case (data_i.sector)
      SecRed:   base = BaseRed;
      SecGreen: base = BaseGreen;
      SecBlue:  base = BaseBlue;
      default:  base = '0;
    endcase
    sum = base + 10'(data_i.hquo);
    if (sum >= HueFull) sum = sum - HueFull;
    hue_d = (data_i.sector == SecGrey) ? '0 : sum[HueW-1:0];
    sat_d = (data_i.value == '0) ? '0 : data_i.squo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= data_i.value;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;

endmodule

@@ tb/tb.sv @@
module tb;
  import rgbhsv_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] sat;
    logic [ChW-1:0]  value;
  } hsv_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // hue [8:0], saturation [22:9], value [30:23]

  hsv_t hsv_expected_q[$];
  int   mismatch_count;
  int   idle_cycles;
  bit   full_rate;

  rgb_to_hsv_pixel_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic hsv_t predict_hsv(input logic [7:0] red, input logic [7:0] green,
                                       input logic [7:0] blue);
    int   r, g, b, cmax, cmin, diff, pair, base;
    hsv_t res;
    r = red;
    g = green;
    b = blue;
    cmax = (r > g) ? r : g;
    if (b > cmax) cmax = b;
    cmin = (r < g) ? r : g;
    if (b < cmin) cmin = b;
    diff = cmax - cmin;
    res.hue   = '0;
    res.sat   = '0;
    res.value = cmax[7:0];
    if (diff != 0) begin
      // Red wins ties over green, and green over blue.
      if (cmax == r) begin
        pair = g - b;
        base = 360;
      end else if (cmax == g) begin
        pair = b - r;
        base = 120;
      end else begin
        pair = r - g;
        base = 240;
      end
      // The offset keeps the dividend non-negative, so the divide truncates to the floor.
      res.hue = HueW'(((60 * pair + base * diff) / diff) % 360);
    end
    if (cmax != 0) res.sat = SatW'((diff * 10000) / cmax);
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {blue, green, red};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    hsv_expected_q.push_back(predict_hsv(red, green, blue));
    @(negedge clk_i);
  endtask

  // Draws a pixel from a mix of shapes so that small differences, ties and
  // grey levels show up far more often than uniform draws would give.
  task automatic random_pixel(output logic [7:0] red, output logic [7:0] green,
                              output logic [7:0] blue);
    int shape, base, pick, v;
    int ch[3];
    shape = $urandom_range(0, 9);
    base  = $urandom_range(0, 255);
    for (int i = 0; i < 3; i++) ch[i] = $urandom_range(0, 255);
    if (shape == 4 || shape == 5) begin
      for (int i = 0; i < 3; i++) begin
        v = base + $urandom_range(0, 6) - 3;
        ch[i] = (v < 0) ? 0 : ((v > 255) ? 255 : v);
      end
    end else if (shape == 6 || shape == 7) begin
      pick = $urandom_range(0, 2);
      ch[pick] = ch[(pick + 1) % 3];
    end else if (shape == 8) begin
      pick = $urandom_range(0, 2);
      ch[pick] = $urandom_range(0, 1) ? 255 : 0;
    end else if (shape == 9) begin
      for (int i = 0; i < 3; i++) ch[i] = base;
    end
    red   = ch[0][7:0];
    green = ch[1][7:0];
    blue  = ch[2][7:0];
  endtask

  task automatic send_random_pixels(input int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Holds off new requests until every pending result has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (hsv_expected_q.size() != 0);
  endtask

  task automatic test_corner_pixels();
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);    // red ties green
    send_pixel(8'd255, 8'd0,   8'd255);  // red ties blue
    send_pixel(8'd0,   8'd255, 8'd255);  // green ties blue
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd1,   8'd0,   8'd1);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd1);    // hue just under a full turn
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd0,   8'd85,  8'd170);
    send_pixel(8'd85,  8'd170, 8'd255);
    send_pixel(8'd3,   8'd2,   8'd1);
    send_pixel(8'd2,   8'd255, 8'd1);
  endtask

  task automatic test_back_to_back();
    full_rate = 1'b1;
    send_random_pixels(60);
    full_rate = 1'b0;
  endtask

  task automatic test_pause_and_resume();
    send_random_pixels(20);
    wait_for_drain();
    send_random_pixels(20);
  endtask

  task automatic test_random_pixels();
    send_random_pixels(300);
    full_rate = 1'b1;
    send_random_pixels(30);
    full_rate = 1'b0;
    send_random_pixels(300);
  endtask

  // Output side: random stalls before each result, none while running at full rate.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = full_rate ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    hsv_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hue   = m_axis_tdata[8:0];
      got.sat   = m_axis_tdata[22:9];
      got.value = m_axis_tdata[30:23];
      if (hsv_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected result: hue %0d sat %0d value %0d",
                   got.hue, got.sat, got.value);
      end else begin
        want = hsv_expected_q.pop_front();
        if (got.hue !== want.hue || got.sat !== want.sat || got.value !== want.value) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: expected hue %0d sat %0d value %0d, got hue %0d sat %0d value %0d",
                     want.hue, want.sat, want.value, got.hue, got.sat, got.value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("rgb_to_hsv_pixel_converter regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    full_rate      = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_pixels();
    test_back_to_back();
    test_pause_and_resume();
    test_random_pixels();

    wait_for_drain();
    // Any stray result after the last expected one is caught by the checker.
    repeat (40) @(posedge clk_i);
    mismatch_count += hsv_expected_q.size();
    if (mismatch_count == 0)
      $display("rgb_to_hsv_pixel_converter regression: pass");
    else
      $display("rgb_to_hsv_pixel_converter regression: fail");
    $finish;
  end

endmodule
